@@ hdl/mse_pkg.sv @@
// Shared types and constants for the merge sort engine.
`default_nettype none

package mse_pkg;

  localparam int KEY_W        = 32;
  localparam int MAX_KEYS_DEF = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_in;
    logic                    batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic                    last_out;
    logic                    overflowed;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/merge_sort_engine_top.sv @@
// Top level of the merge sort engine: load, bottom-up merge passes, read-out.
//
// Usage:
//   Keys enter on the key channel (key_valid / key_stall / key_item), one key
//   per item; batch_end marks the final key. Keys beyond MAX_KEYS are dropped
//   and flag every result of that batch as overflowed.
//   After the final key the engine sorts the batch in ascending signed order
//   and returns it on the result channel (res_valid / res_stall / res_item),
//   one key per item, last_out on the final one.
// Flow:
//   Loading takes one key per cycle. Sorting n keys takes ceil(log2 n)
//   passes; each pair of runs starts in ST_RUN, which covers the registered
//   read of the key memory, and then merges one key per cycle in ST_MERGE.
//   After the passes ST_RD does the first read of the sorted array, then
//   results stream one per cycle while res_stall is low. key_stall is high
//   from the final key until the last result is taken.
// Reset: synchronous, clears the key count, overflow flag and sequencer;
//   memory contents are not cleared (only written entries are ever used).
// Stall: while res_stall is high the current result holds; the memory keeps
//   re-reading the same entry so the payload is stable.
`default_nettype none

module merge_sort_engine_top #(
  parameter int MAX_KEYS = mse_pkg::MAX_KEYS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               key_valid,
  output logic                    key_stall,
  input  wire mse_pkg::in_item_t  key_item,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output mse_pkg::out_item_t      res_item
);

  localparam int AW = $clog2(MAX_KEYS);
  // positions, run bounds and run widths; headroom for lo + 2*width
  localparam int CW = $clog2(MAX_KEYS + 1) + 2;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,  // taking keys
    ST_RUN   = 5'b00010,  // first read of a run pair
    ST_MERGE = 5'b00100,  // one merged key per cycle
    ST_RD    = 5'b01000,  // first read of the sorted array
    ST_OUT   = 5'b10000   // presenting results
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;   // keys held in this batch
  logic            ovf, ovf_next;
  logic            src_sel, src_sel_next; // memory holding current runs
  logic [CW-1:0]   width, width_next;
  logic [CW-1:0]   lo, lo_next;
  logic [CW-1:0]   mid, mid_next;
  logic [CW-1:0]   hi, hi_next;
  logic [CW-1:0]   a, a_next;
  logic [CW-1:0]   b, b_next;
  logic [CW-1:0]   k, k_next;
  logic [CW-1:0]   idx, idx_next;

  logic                      key_acc, res_acc;
  logic                      room;
  logic [CW-1:0]             run_mid, run_hi, lo_step, width_dbl;
  logic [mse_pkg::KEY_W-1:0] key_a, key_b, merge_key;
  logic                      take_a;
  logic [CW-1:0]             a_adv, b_adv;
  logic [CW-1:0]             raddr_a_full, raddr_b_full;

  logic [AW-1:0]             waddr0, waddr1;
  logic [mse_pkg::KEY_W-1:0] wdata0;
  logic                      we0, we1;
  logic [mse_pkg::KEY_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

  assign key_stall = (state != ST_LOAD);
  assign key_acc   = key_valid && !key_stall;
  assign res_valid = (state == ST_OUT);
  assign res_acc   = res_valid && !res_stall;
  assign room      = (count < CW'(MAX_KEYS));

  // run geometry, clipped to the batch size
  assign width_dbl = width << 1;
  assign lo_step   = lo + width_dbl;
  always_comb begin
    run_mid = lo + width;
    if (run_mid > count) begin
      run_mid = count;
    end
    run_hi = lo_step;
    if (run_hi > count) begin
      run_hi = count;
    end
  end

  // merge decision; ties take the right run, invisible in the output
  assign key_a     = src_sel ? rd1_a : rd0_a;
  assign key_b     = src_sel ? rd1_b : rd0_b;
  assign take_a    = (a < mid) && ((b >= hi) || ($signed(key_a) < $signed(key_b)));
  assign merge_key = take_a ? key_a : key_b;
  assign a_adv     = take_a ? a + CW'(1) : a;
  assign b_adv     = take_a ? b : b + CW'(1);

  // read addresses go to both memories; only the source side is used
  always_comb begin
    raddr_a_full = '0;
    raddr_b_full = '0;
    unique case (state)
      ST_LOAD: begin
      end
      ST_RUN: begin
        raddr_a_full = lo;
        raddr_b_full = run_mid;
      end
      ST_MERGE: begin
        raddr_a_full = a_adv;
        raddr_b_full = b_adv;
      end
      ST_RD: begin
        raddr_a_full = idx;
      end
      ST_OUT: begin
        raddr_a_full = res_acc ? idx + CW'(1) : idx;
      end
      default: begin
      end
    endcase
  end

  // memory 0 takes loads and even-numbered merge passes, memory 1 odd-numbered ones (the first pass writes memory 1)
  assign we0    = (key_acc && room) || (state == ST_MERGE && src_sel);
  assign waddr0 = (state == ST_LOAD) ? count[AW-1:0] : k[AW-1:0];
  assign wdata0 = (state == ST_LOAD) ? key_item.key_in : merge_key;
  assign we1    = (state == ST_MERGE) && !src_sel;
  assign waddr1 = k[AW-1:0];

  mse_ram #(.DEPTH(MAX_KEYS)) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a_full[AW-1:0]),
    .raddr_b (raddr_b_full[AW-1:0]),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_ram #(.DEPTH(MAX_KEYS)) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr1),
    .wdata   (merge_key),
    .raddr_a (raddr_a_full[AW-1:0]),
    .raddr_b (raddr_b_full[AW-1:0]),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    src_sel_next = src_sel;
    width_next   = width;
    lo_next      = lo;
    mid_next     = mid;
    hi_next      = hi;
    a_next       = a;
    b_next       = b;
    k_next       = k;
    idx_next     = idx;
    unique case (state)
      ST_LOAD: begin
        if (key_acc) begin
          if (room) begin
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (key_item.batch_end) begin
            width_next   = CW'(1);
            lo_next      = '0;
            src_sel_next = 1'b0;
            idx_next     = '0;
            state_next   = (count_next > CW'(1)) ? ST_RUN : ST_RD;
          end
        end
      end
      ST_RUN: begin
        mid_next   = run_mid;
        hi_next    = run_hi;
        a_next     = lo;
        b_next     = run_mid;
        k_next     = lo;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        a_next = a_adv;
        b_next = b_adv;
        k_next = k + CW'(1);
        if (k + CW'(1) == hi) begin
          if (lo_step >= count) begin
            // pass complete: runs now live in the other memory
            lo_next      = '0;
            width_next   = width_dbl;
            src_sel_next = !src_sel;
            state_next   = (width_dbl >= count) ? ST_RD : ST_RUN;
          end else begin
            lo_next    = lo_step;
            state_next = ST_RUN;
          end
        end
      end
      ST_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (res_acc) begin
          if (idx + CW'(1) == count) begin
            count_next   = '0;
            ovf_next     = 1'b0;
            src_sel_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      src_sel <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      src_sel <= src_sel_next;
    end
    width <= width_next;
    lo    <= lo_next;
    mid   <= mid_next;
    hi    <= hi_next;
    a     <= a_next;
    b     <= b_next;
    k     <= k_next;
    idx   <= idx_next;
  end

  assign res_item.key_out    = key_a;
  assign res_item.last_out   = (idx + CW'(1) == count);
  assign res_item.overflowed = ovf;

endmodule

`default_nettype wire

@@ hdl/mse_ram.sv @@
// Key memory: one write port, two registered read ports.
`default_nettype none

module mse_ram #(
  parameter int DEPTH = mse_pkg::MAX_KEYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [mse_pkg::KEY_W-1:0]      wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_b,
  output logic      [mse_pkg::KEY_W-1:0]      rdata_a,
  output logic      [mse_pkg::KEY_W-1:0]      rdata_b
);

  logic [mse_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the merge sort engine: batch stimulus, sort prediction, checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W       = mse_pkg::KEY_W;
  localparam int CAPACITY    = mse_pkg::MAX_KEYS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_ITEMS  = 40;   // no idling once this few keys remain
  localparam int RAND_ITEMS  = 350;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // one key waiting to be sent; hold_for_drain makes the sender wait until
  // every expected result is back before offering it
  typedef struct {
    mse_pkg::in_item_t item;
    bit                hold_for_drain;
  } key_send_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               key_valid = 1'b0;
  logic               key_stall;
  mse_pkg::in_item_t  key_item = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  mse_pkg::out_item_t res_item;

  key_send_t                keys_to_send[$];
  mse_pkg::out_item_t       sorted_expected[$];
  logic signed [KEY_W-1:0]  batch_keys[$];
  bit                       batch_dropped = 1'b0;

  int mismatches = 0;
  int key_gap    = 0;
  int res_hold   = 0;
  int cycles     = 0;

  merge_sort_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_item  (key_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Sort prediction. Keys of the open batch are kept until the final key;
  // anything past capacity is dropped and flags the whole batch. On the
  // final key the batch is put in ascending signed order (insertion sort;
  // the order of equal keys cannot be seen) and queued as expected results.
  // ---------------------------------------------------------------------
  task automatic predict_sorted(input mse_pkg::in_item_t it);
    logic signed [KEY_W-1:0] cur;
    mse_pkg::out_item_t      res;
    int                      j;
    if (batch_keys.size() < CAPACITY) begin
      batch_keys.push_back(it.key_in);
    end else begin
      batch_dropped = 1'b1;
    end
    if (it.batch_end) begin
      for (int i = 1; i < batch_keys.size(); i++) begin
        cur = batch_keys[i];
        j = i - 1;
        while (j >= 0 && batch_keys[j] > cur) begin
          batch_keys[j+1] = batch_keys[j];
          j--;
        end
        batch_keys[j+1] = cur;
      end
      foreach (batch_keys[i]) begin
        res.key_out    = batch_keys[i];
        res.last_out   = (i == batch_keys.size() - 1);
        res.overflowed = batch_dropped;
        sorted_expected.push_back(res);
      end
      batch_keys.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  task automatic queue_key(input logic signed [KEY_W-1:0] k, input bit last,
                           input bit drain);
    key_send_t e;
    e.item.key_in    = k;
    e.item.batch_end = last;
    e.hold_for_drain = drain;
    keys_to_send.push_back(e);
  endtask

  // mix of extremes, a narrow band (plenty of equal keys) and full range
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3:    return KEY_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_batch(input int n, input bit drain);
    for (int i = 0; i < n; i++) begin
      queue_key(pick_key(), i == n - 1, drain && i == 0);
    end
  endtask

  initial begin
    int sent;
    int b;
    int n;

    // directed: single-key batches at the extremes and zero
    queue_key(KEY_MIN, 1'b1, 1'b0);
    queue_key(KEY_MAX, 1'b1, 1'b0);
    queue_key('0, 1'b1, 1'b0);
    // mixed signs, extremes and a repeated key in one batch
    queue_key(5, 1'b0, 1'b0);
    queue_key(-5, 1'b0, 1'b0);
    queue_key(KEY_MAX, 1'b0, 1'b0);
    queue_key(KEY_MIN, 1'b0, 1'b0);
    queue_key(-1, 1'b0, 1'b0);
    queue_key(0, 1'b0, 1'b0);
    queue_key(5, 1'b0, 1'b0);
    queue_key(1, 1'b1, 1'b0);
    // all keys equal
    queue_key(7, 1'b0, 1'b0);
    queue_key(7, 1'b0, 1'b0);
    queue_key(7, 1'b1, 1'b0);
    // two keys in descending order
    queue_key(100, 1'b0, 1'b0);
    queue_key(-100, 1'b1, 1'b0);
    // already ascending
    queue_key(-3, 1'b0, 1'b0);
    queue_key(-2, 1'b0, 1'b0);
    queue_key(-1, 1'b0, 1'b0);
    queue_key(0, 1'b1, 1'b0);

    // random batches: mostly short, with a full store, an overflow whose
    // final key is itself dropped, and a few more large ones
    sent = 0;
    b = 0;
    while (sent < RAND_ITEMS) begin
      case (b)
        2:       n = CAPACITY;
        5:       n = CAPACITY + 2;
        8:       n = CAPACITY + 1;
        default: n = ($urandom_range(0, 19) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                                                 : $urandom_range(1, 12);
      endcase
      queue_batch(n, b == 4 || b == 10);
      sent += n;
      b++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (keys_to_send.size() != 0) @(posedge clk);
    while (sorted_expected.size() != 0) @(posedge clk);
    // engine should be quiet now; anything arriving here is unexpected
    repeat (30) @(posedge clk);

    if (mismatches == 0 && sorted_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Key driver. The head item stays on the bus until accepted; between
  // items the sender idles in random bursts, except near the end.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      if (key_valid && !key_stall) begin
        predict_sorted(key_item);
        void'(keys_to_send.pop_front());
      end
      if (key_valid && key_stall) begin
        // stalled: payload holds
      end else if (key_gap > 0) begin
        key_gap--;
        key_valid <= 1'b0;
      end else if (keys_to_send.size() == 0) begin
        key_valid <= 1'b0;
      end else if (keys_to_send[0].hold_for_drain && sorted_expected.size() != 0) begin
        key_valid <= 1'b0;
      end else if (keys_to_send.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        key_gap = $urandom_range(1, 6) - 1;
        key_valid <= 1'b0;
      end else begin
        key_valid <= 1'b1;
        key_item  <= keys_to_send[0].item;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest expected
  // one, and stall the result channel in random bursts.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mse_pkg::out_item_t want;
    logic               stall_next;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (sorted_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: key %0d last %0b ovf %0b",
                     res_item.key_out, res_item.last_out, res_item.overflowed);
          end
        end else begin
          want = sorted_expected.pop_front();
          if (res_item.key_out !== want.key_out || res_item.last_out !== want.last_out ||
              res_item.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: key exp %0d got %0d, last exp %0b got %0b, ovf exp %0b got %0b",
                       want.key_out, res_item.key_out, want.last_out, res_item.last_out,
                       want.overflowed, res_item.overflowed);
            end
          end
        end
      end
      if (res_hold > 0) begin
        res_hold--;
        stall_next = 1'b1;
      end else if (keys_to_send.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        res_hold = $urandom_range(1, 6) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      res_stall <= stall_next;
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/merge_sort_engine_top.sv
sim/tb.sv
